// ===== rtl/rdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared widths, register indexes and reset values for the radial distortion
// coordinate map.
// ----------------------------------------------------------------------------
package rdm_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int PIX_W   = 10;
  localparam int SCALE_W = 18;
  localparam int SHIFT_W = 24;
  localparam int GAIN_W  = 32;
  localparam int COORD_W = 24;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 48;
  localparam int STAGES  = 9;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_GAIN      = 3'd2,
    CFG_SCALE_EN  = 3'd3,
    CFG_SHIFT_X   = 3'd4,
    CFG_SHIFT_Y   = 3'd5,
    CFG_SCALE_X   = 3'd6,
    CFG_SCALE_Y   = 3'd7
  } cfg_idx_t;

  localparam logic [PIX_W-1:0]          CENTER_RST   = 10'd320;
  localparam logic signed [GAIN_W-1:0]  GAIN_RST     = 32'sd109951163;
  localparam logic                      SCALE_EN_RST = 1'b1;
  localparam logic signed [SHIFT_W-1:0] SHIFT_RST    = 24'sd0;
  localparam logic [SCALE_W-1:0]        SCALE_RST    = 18'd65536;

  localparam logic [COORD_W-1:0] SAT_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 24'h800000;

  // Per-axis values carried down the pipeline
  typedef struct packed {
    logic signed [24:0] pp;
    logic signed [25:0] d;
  } axis_carry_t;

endpackage

// ===== rtl/radial_distortion_map_top.sv =====
// ----------------------------------------------------------------------------
// radial_distortion_map_top
// Maps an output pixel coordinate to its source coordinate under cubic radial
// lens distortion, with optional per-axis scale and shift beforehand.
//
// Input channel in_*: one word per pixel, pixel_x and pixel_y.
// Output channel out_*: one word per input, source_x and source_y in signed
// fixed point with 8 fraction bits, saturated to 24 bits.
// Configuration cfg_*: write cfg_wdata to register cfg_addr while cfg_we is
// high; change registers only while no word is in flight.
// An accepted input word passes through every stage to out_tvalid. Throughput
// is one word per cycle while the receiver does not stall, through the nine-stage multiply and add pipeline.
// Reset clears every stage valid and restores the register defaults.
// When the receiver stalls, the stages fill their empty slots first and
// then hold; in_tready drops only once every stage holds a word.
// ----------------------------------------------------------------------------
module radial_distortion_map_top #(
  parameter int MAX_DIM = rdm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel_x [9:0], pixel_y [19:10], zero [23:20]
  input  logic [rdm_pkg::IN_DW-1:0]     in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // source_x [23:0], source_y [47:24]
  output logic [rdm_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [rdm_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [rdm_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int NS      = rdm_pkg::STAGES;
  localparam int PixMax  = (MAX_DIM - 1 > 1023) ? 1023 : MAX_DIM - 1;
  localparam logic [rdm_pkg::PIX_W-1:0] PIX_MAX_C = rdm_pkg::PIX_W'(PixMax);

  // Configuration registers
  logic [9:0]         center_x_r, center_y_r;
  logic signed [31:0] gain_r;
  logic               scale_en_r;
  logic signed [23:0] shift_x_r, shift_y_r;
  logic [17:0]        scale_x_r, scale_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= rdm_pkg::CENTER_RST;
      center_y_r <= rdm_pkg::CENTER_RST;
      gain_r     <= rdm_pkg::GAIN_RST;
      scale_en_r <= rdm_pkg::SCALE_EN_RST;
      shift_x_r  <= rdm_pkg::SHIFT_RST;
      shift_y_r  <= rdm_pkg::SHIFT_RST;
      scale_x_r  <= rdm_pkg::SCALE_RST;
      scale_y_r  <= rdm_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (rdm_pkg::cfg_idx_t'(cfg_addr))
        rdm_pkg::CFG_CENTER_X: center_x_r <= cfg_wdata[9:0];
        rdm_pkg::CFG_CENTER_Y: center_y_r <= cfg_wdata[9:0];
        rdm_pkg::CFG_GAIN:     gain_r     <= $signed(cfg_wdata);
        rdm_pkg::CFG_SCALE_EN: scale_en_r <= cfg_wdata[0];
        rdm_pkg::CFG_SHIFT_X:  shift_x_r  <= $signed(cfg_wdata[23:0]);
        rdm_pkg::CFG_SHIFT_Y:  shift_y_r  <= $signed(cfg_wdata[23:0]);
        rdm_pkg::CFG_SCALE_X:  scale_x_r  <= cfg_wdata[17:0];
        rdm_pkg::CFG_SCALE_Y:  scale_y_r  <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  // Stage valids and advance enables
  logic [NS:1] vld_r;
  logic [NS:1] stage_en;
  logic [NS:1] vld_nxt;

  always_comb begin
    stage_en[NS] = out_tready | ~vld_r[NS];
    for (int i = NS - 1; i >= 1; i--) begin
      stage_en[i] = stage_en[i+1] | ~vld_r[i];
    end
  end

  always_comb begin
    vld_nxt[1] = in_tvalid;
    for (int i = 2; i <= NS; i++) begin
      vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (stage_en[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  assign in_tready = stage_en[1];

  // Stage 1: clamp and scale multiply
  logic [9:0]  pix_x_w, pix_y_w;
  logic [9:0]  px1_r, py1_r;
  logic [27:0] prodx1_r, prody1_r;

  assign pix_x_w = (in_tdata[9:0] > PIX_MAX_C) ? PIX_MAX_C : in_tdata[9:0];
  assign pix_y_w = (in_tdata[19:10] > PIX_MAX_C) ? PIX_MAX_C : in_tdata[19:10];

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      px1_r    <= pix_x_w;
      py1_r    <= pix_y_w;
      prodx1_r <= {18'd0, pix_x_w} * {10'd0, scale_x_r};
      prody1_r <= {18'd0, pix_y_w} * {10'd0, scale_y_r};
    end
  end

  // Stage 2: shift and centre offset
  logic signed [24:0] ppx_w, ppy_w;
  rdm_pkg::axis_carry_t carx_r [2:8];
  rdm_pkg::axis_carry_t cary_r [2:8];

  assign ppx_w = scale_en_r ? ($signed({5'd0, prodx1_r[27:8]}) + {shift_x_r[23], shift_x_r})
                            : $signed({7'd0, px1_r, 8'd0});
  assign ppy_w = scale_en_r ? ($signed({5'd0, prody1_r[27:8]}) + {shift_y_r[23], shift_y_r})
                            : $signed({7'd0, py1_r, 8'd0});

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      carx_r[2].pp <= ppx_w;
      carx_r[2].d  <= {ppx_w[24], ppx_w} - $signed({8'd0, center_x_r, 8'd0});
      cary_r[2].pp <= ppy_w;
      cary_r[2].d  <= {ppy_w[24], ppy_w} - $signed({8'd0, center_y_r, 8'd0});
    end
    for (int i = 3; i <= 8; i++) begin
      if (stage_en[i]) begin
        carx_r[i] <= carx_r[i-1];
        cary_r[i] <= cary_r[i-1];
      end
    end
  end

  // Stage 3: squares
  logic signed [51:0] sqx_w, sqy_w;
  logic [46:0]        sqx3_r, sqy3_r;

  assign sqx_w = carx_r[2].d * carx_r[2].d;
  assign sqy_w = cary_r[2].d * cary_r[2].d;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      sqx3_r <= sqx_w[46:0];
      sqy3_r <= sqy_w[46:0];
    end
  end

  // Stage 4: squared radius
  logic [47:0] r2_4_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) r2_4_r <= {1'b0, sqx3_r} + {1'b0, sqy3_r};
  end

  // Stage 5: gain times radius halves
  logic signed [56:0] mhi5_r, mlo5_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      mhi5_r <= gain_r * $signed({1'b0, r2_4_r[47:24]});
      mlo5_r <= gain_r * $signed({1'b0, r2_4_r[23:0]});
    end
  end

  // Stage 6: radial factor, 32 fraction bits
  logic signed [56:0] f6_r;

  always_ff @(posedge clk) begin
    if (stage_en[6]) f6_r <= mhi5_r + (mlo5_r >>> 24);
  end

  // Stage 7: offset times factor halves
  logic signed [24:0] fhi_w;
  logic signed [32:0] flo_w;
  logic signed [50:0] ax7_r, ay7_r;
  logic signed [58:0] bx7_r, by7_r;

  assign fhi_w = f6_r[56:32];
  assign flo_w = $signed({1'b0, f6_r[31:0]});

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      ax7_r <= carx_r[6].d * fhi_w;
      ay7_r <= cary_r[6].d * fhi_w;
      bx7_r <= carx_r[6].d * flo_w;
      by7_r <= cary_r[6].d * flo_w;
    end
  end

  // Stage 8: distortion term
  logic signed [51:0] termx8_r, termy8_r;

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      termx8_r <= {ax7_r[50], ax7_r} + {{25{bx7_r[58]}}, bx7_r[58:32]};
      termy8_r <= {ay7_r[50], ay7_r} + {{25{by7_r[58]}}, by7_r[58:32]};
    end
  end

  // Stage 9: add and saturate
  logic signed [52:0] sumx_w, sumy_w;
  logic [23:0]        srcx_w, srcy_w;
  logic [23:0]        srcx9_r, srcy9_r;

  assign sumx_w = {{28{carx_r[8].pp[24]}}, carx_r[8].pp} + {termx8_r[51], termx8_r};
  assign sumy_w = {{28{cary_r[8].pp[24]}}, cary_r[8].pp} + {termy8_r[51], termy8_r};

  always_comb begin
    if ((sumx_w[52:23] == '0) || (sumx_w[52:23] == '1)) srcx_w = sumx_w[23:0];
    else srcx_w = sumx_w[52] ? rdm_pkg::SAT_MIN : rdm_pkg::SAT_MAX;
    if ((sumy_w[52:23] == '0) || (sumy_w[52:23] == '1)) srcy_w = sumy_w[23:0];
    else srcy_w = sumy_w[52] ? rdm_pkg::SAT_MIN : rdm_pkg::SAT_MAX;
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      srcx9_r <= srcx_w;
      srcy9_r <= srcy_w;
    end
  end

  assign out_tvalid = vld_r[NS];
  assign out_tdata  = {srcy9_r, srcx9_r};

  // Checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !stage_en[4] |=> vld_r[4] && $stable(r2_4_r))
    else $error("held stage lost its word");

  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] && stage_en[9] && !sumx_w[52] && (sumx_w[52:23] != '0)
    |=> out_tdata[23:0] == rdm_pkg::SAT_MAX)
    else $error("positive overflow not saturated");

endmodule
